// ===== rtl/core/tlbpt_pkg.sv =====
// Shared types and constants for the TLB and page-table translator.
`default_nettype none
package tlbpt_pkg;

   localparam int PAGE_W     = 8;
   localparam int OFF_W      = 8;
   localparam int FRAME_W    = 8;
   localparam int ADDR_W     = 16;
   localparam int PAGE_COUNT = 256;
   localparam int MAX_FRAMES = 256;
   localparam int FCOUNT_W   = 9;
   localparam int CNT_W      = 32;
   localparam int RING_AW    = 12;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = 8'd1;

   typedef enum logic [2:0] {
      RING_RD_NEXT = 3'b001,
      RING_RD_PREV = 3'b010,
      RING_MOVE    = 3'b100
   } ring_op_type;

   typedef struct packed {
      logic                 valid;
      ring_op_type          op;
      logic [RING_AW-1:0]   head;
      logic [RING_AW-1:0]   node;
   } ring_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [RING_AW-1:0]   data;
   } ring_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/tlbpt_ring.sv =====
// Doubly linked ring in two memories: link reads and move-after-head sequencer.
`default_nettype none
module tlbpt_ring #(
   parameter int DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         clear,
   input  wire logic [$clog2(DEPTH):0]       ring_len,
   input  wire tlbpt_pkg::ring_cmd_type      cmd,
   output tlbpt_pkg::ring_rsp_type           rsp
);

   localparam int IW = $clog2(DEPTH);

   typedef enum logic [5:0] {
      R_IDLE = 6'b000001,
      R_RD   = 6'b000010,
      R_MA   = 6'b000100,
      R_MB   = 6'b001000,
      R_MC   = 6'b010000,
      R_MD   = 6'b100000
   } rstate_type;

   rstate_type state_ff, state_in;
   logic [IW-1:0] nx_mem [DEPTH];
   logic [IW-1:0] pv_mem [DEPTH];
   logic [DEPTH-1:0] nxw_ff, pvw_ff;
   logic [IW-1:0] head_ff, node_ff, addr_ff, c_ff;
   logic prev_sel_ff;
   logic [IW-1:0] nx_q, pv_q;
   logic nxw_q, pvw_q;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] nx_val, pv_val, nx_def, pv_def;
   logic nx_we, pv_we;
   logic [IW-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata;
   logic in_ring;

   always_comb begin
      case (state_ff)
         R_IDLE:  rd_addr = cmd.node[IW-1:0];
         R_MB:    rd_addr = head_ff;
         default: rd_addr = node_ff;
      endcase
   end

   assign in_ring = {1'b0, addr_ff} < ring_len;
   assign nx_def  = !in_ring ? '0 :
                    (({1'b0, addr_ff} + (IW+1)'(1)) == ring_len) ? '0 : addr_ff + IW'(1);
   assign pv_def  = !in_ring ? '0 :
                    (addr_ff == '0) ? IW'(ring_len - (IW+1)'(1)) : addr_ff - IW'(1);
   assign nx_val  = nxw_q ? nx_q : nx_def;
   assign pv_val  = pvw_q ? pv_q : pv_def;

   always_comb begin
      nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
      pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0;
      state_in = state_ff;
      case (state_ff)
         R_IDLE: begin
            if (cmd.valid) begin
               state_in = (cmd.op == tlbpt_pkg::RING_MOVE) ? R_MA : R_RD;
            end
         end
         R_RD: state_in = R_IDLE;
         R_MA: begin
            nx_we = 1'b1; nx_waddr = pv_val; nx_wdata = nx_val;
            pv_we = 1'b1; pv_waddr = nx_val; pv_wdata = pv_val;
            state_in = R_MB;
         end
         R_MB: state_in = R_MC;
         R_MC: begin
            nx_we = 1'b1; nx_waddr = node_ff; nx_wdata = nx_val;
            pv_we = 1'b1; pv_waddr = node_ff; pv_wdata = head_ff;
            state_in = R_MD;
         end
         R_MD: begin
            pv_we = 1'b1; pv_waddr = c_ff; pv_wdata = node_ff;
            nx_we = 1'b1; nx_waddr = head_ff; nx_wdata = node_ff;
            state_in = R_IDLE;
         end
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         nxw_ff   <= '0;
         pvw_ff   <= '0;
      end else begin
         state_ff <= clear ? R_IDLE : state_in;
         if (clear) begin
            nxw_ff <= '0;
            pvw_ff <= '0;
         end else begin
            if (nx_we) nxw_ff[nx_waddr] <= 1'b1;
            if (pv_we) pvw_ff[pv_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
      if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
      nx_q    <= nx_mem[rd_addr];
      pv_q    <= pv_mem[rd_addr];
      nxw_q   <= nxw_ff[rd_addr];
      pvw_q   <= pvw_ff[rd_addr];
      addr_ff <= rd_addr;
      if (state_ff == R_IDLE && cmd.valid) begin
         head_ff     <= cmd.head[IW-1:0];
         node_ff     <= cmd.node[IW-1:0];
         prev_sel_ff <= (cmd.op == tlbpt_pkg::RING_RD_PREV);
      end
      if (state_ff == R_MC) c_ff <= nx_val;
   end

   assign rsp.done = (state_ff == R_RD) || (state_ff == R_MD);
   assign rsp.data = tlbpt_pkg::RING_AW'(prev_sel_ff ? pv_val : nx_val);

endmodule
`default_nettype wire

// ===== rtl/core/tlb_page_table_translator.sv =====
// Top level: TLB, page map, frame ring and translation sequencer.
//
//  channel  | ports                                   | handshake
//  request  | start, busy, req_logical_address        | taken when start & !busy
//  response | rsp_valid, rsp_*                        | one-cycle strobe, no stall
//  csr      | csr_valid, csr_ready, csr_index, csr_data | valid & ready
//
// busy is shortest on a TLB hit without reordering and longest on a page fault that
// moves a TLB entry, which takes link reads and a ring move.
// busy holds through the response strobe, so transactions never overlap.
// Reset is synchronous; all maps start empty with no clearing pass.
// A frame-count write clears all maps at once. The receiver cannot stall.
`default_nettype none
module tlb_page_table_translator #(
   parameter int TLB_ENTRIES = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [tlbpt_pkg::ADDR_W-1:0]         req_logical_address,
   output logic                                      rsp_valid,
   output logic [tlbpt_pkg::ADDR_W-1:0]              rsp_phys_addr,
   output logic [tlbpt_pkg::FRAME_W-1:0]             rsp_frame_index,
   output logic                                      rsp_tlb_hit,
   output logic                                      rsp_page_fault,
   output logic                                      rsp_evicted_valid,
   output logic [tlbpt_pkg::PAGE_W-1:0]              rsp_evicted_page,
   output logic [tlbpt_pkg::CNT_W-1:0]               rsp_fault_total,
   output logic [tlbpt_pkg::CNT_W-1:0]               rsp_hit_total,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tlbpt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tlbpt_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int TW = $clog2(TLB_ENTRIES);
   localparam int PW = tlbpt_pkg::PAGE_W;
   localparam int FW = tlbpt_pkg::FRAME_W;
   localparam int AW = tlbpt_pkg::RING_AW;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_LOOK  = 11'b00000000010,
      S_TMOVE = 11'b00000000100,
      S_FMOVE = 11'b00000001000,
      S_FNEXT = 11'b00000010000,
      S_OWN   = 11'b00000100000,
      S_UNMAP = 11'b00001000000,
      S_TPREV = 11'b00010000000,
      S_TNEXT = 11'b00100000000,
      S_TFILL = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic policy_ff;
   logic [tlbpt_pkg::FCOUNT_W-1:0] fin_ff, fin_clamp;
   logic [FW-1:0] fcur_ff;
   logic [TW-1:0] tcur_ff;
   logic [tlbpt_pkg::CNT_W-1:0] fcnt_ff, hcnt_ff;

   logic [TLB_ENTRIES-1:0] tvld_ff;
   logic [PW-1:0] ttag_ff [TLB_ENTRIES];
   logic [FW-1:0] tdata_ff [TLB_ENTRIES];

   logic [FW-1:0] pm_mem [tlbpt_pkg::PAGE_COUNT];
   logic [tlbpt_pkg::PAGE_COUNT-1:0] pm_vld_ff;
   logic [FW-1:0] pm_q;
   logic pmv_q;

   logic [PW-1:0] own_mem [tlbpt_pkg::MAX_FRAMES];
   logic [tlbpt_pkg::MAX_FRAMES-1:0] own_vld_ff;
   logic [PW-1:0] own_q;
   logic ownv_q;

   logic [PW-1:0] page_ff;
   logic [tlbpt_pkg::OFF_W-1:0] off_ff;
   logic [FW-1:0] frame_ff;
   logic hit_ff, fault_ff, evv_ff;
   logic [PW-1:0] evp_ff;

   logic cfg_wr, cfg_frames;
   logic lk_hit, inv_hit;
   logic [TW-1:0] lk_idx, inv_idx;
   logic [FW-1:0] fring_f;
   logic [TW-1:0] tring_t;

   tlbpt_pkg::ring_cmd_type tcmd, fcmd;
   tlbpt_pkg::ring_rsp_type trsp, frsp;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;
   assign cfg_wr    = csr_valid && csr_ready;
   assign cfg_frames = cfg_wr && (csr_index == tlbpt_pkg::CSR_FRAMES);

   always_comb begin
      fin_clamp = csr_data;
      if (csr_data == '0) fin_clamp = tlbpt_pkg::FCOUNT_W'(1);
      if (csr_data > tlbpt_pkg::FCOUNT_W'(tlbpt_pkg::MAX_FRAMES))
         fin_clamp = tlbpt_pkg::FCOUNT_W'(tlbpt_pkg::MAX_FRAMES);
   end

   // first matching TLB entry for the current page and for the evicted page
   always_comb begin
      lk_hit = 1'b0; lk_idx = '0;
      inv_hit = 1'b0; inv_idx = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (!lk_hit && tvld_ff[i] && ttag_ff[i] == page_ff) begin
            lk_hit = 1'b1; lk_idx = TW'(i);
         end
         if (!inv_hit && tvld_ff[i] && ttag_ff[i] == own_q) begin
            inv_hit = 1'b1; inv_idx = TW'(i);
         end
      end
   end

   assign fring_f = frsp.data[FW-1:0];
   assign tring_t = trsp.data[TW-1:0];

   always_comb begin
      state_in = state_ff;
      tcmd = '0;
      fcmd = '0;
      tcmd.op = tlbpt_pkg::RING_RD_NEXT;
      fcmd.op = tlbpt_pkg::RING_RD_NEXT;
      case (state_ff)
         S_IDLE: if (start) state_in = S_LOOK;
         S_LOOK: begin
            if (lk_hit) begin
               if (policy_ff && lk_idx != tcur_ff) begin
                  tcmd.valid = 1'b1; tcmd.op = tlbpt_pkg::RING_MOVE;
                  tcmd.head = AW'(tcur_ff); tcmd.node = AW'(lk_idx);
                  state_in = S_TMOVE;
               end else begin
                  state_in = S_DONE;
               end
            end else if (pmv_q) begin
               if (policy_ff && pm_q != fcur_ff) begin
                  fcmd.valid = 1'b1; fcmd.op = tlbpt_pkg::RING_MOVE;
                  fcmd.head = AW'(fcur_ff); fcmd.node = AW'(pm_q);
                  state_in = S_FMOVE;
               end else begin
                  state_in = S_TNEXT;
               end
            end else begin
               fcmd.valid = 1'b1; fcmd.node = AW'(fcur_ff);
               state_in = S_FNEXT;
            end
         end
         S_TMOVE: if (trsp.done) state_in = S_DONE;
         S_FMOVE: if (frsp.done) state_in = S_TNEXT;
         S_FNEXT: if (frsp.done) state_in = S_OWN;
         S_OWN: begin
            if (ownv_q && inv_hit) begin
               tcmd.valid = 1'b1;
               if (inv_idx != tcur_ff) begin
                  tcmd.op = tlbpt_pkg::RING_MOVE;
                  tcmd.head = AW'(tcur_ff); tcmd.node = AW'(inv_idx);
                  state_in = S_UNMAP;
               end else begin
                  tcmd.op = tlbpt_pkg::RING_RD_PREV;
                  tcmd.node = AW'(inv_idx);
                  state_in = S_TPREV;
               end
            end else begin
               state_in = S_TNEXT;
            end
         end
         S_UNMAP: if (trsp.done) state_in = S_TNEXT;
         S_TPREV: if (trsp.done) state_in = S_TNEXT;
         S_TNEXT: begin
            tcmd.valid = 1'b1; tcmd.node = AW'(tcur_ff);
            state_in = S_TFILL;
         end
         S_TFILL: if (trsp.done) state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   tlbpt_ring #(.DEPTH(TLB_ENTRIES)) u_tlb_ring (
      .clock    (clock),
      .reset    (reset),
      .clear    (cfg_frames),
      .ring_len ((TW+1)'(TLB_ENTRIES)),
      .cmd      (tcmd),
      .rsp      (trsp)
   );

   tlbpt_ring #(.DEPTH(tlbpt_pkg::MAX_FRAMES)) u_frame_ring (
      .clock    (clock),
      .reset    (reset),
      .clear    (cfg_frames),
      .ring_len (fin_ff),
      .cmd      (fcmd),
      .rsp      (frsp)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         policy_ff  <= 1'b0;
         fin_ff     <= tlbpt_pkg::FCOUNT_W'(tlbpt_pkg::MAX_FRAMES);
         fcur_ff    <= FW'(tlbpt_pkg::MAX_FRAMES - 1);
         tcur_ff    <= '0;
         fcnt_ff    <= '0;
         hcnt_ff    <= '0;
         tvld_ff    <= '0;
         pm_vld_ff  <= '0;
         own_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr && csr_index == tlbpt_pkg::CSR_POLICY) policy_ff <= csr_data[0];
         if (cfg_frames) begin
            fin_ff     <= fin_clamp;
            fcur_ff    <= FW'(fin_clamp - tlbpt_pkg::FCOUNT_W'(1));
            tcur_ff    <= '0;
            tvld_ff    <= '0;
            pm_vld_ff  <= '0;
            own_vld_ff <= '0;
         end
         case (state_ff)
            S_LOOK: begin
               if (lk_hit) begin
                  if (hcnt_ff != '1) hcnt_ff <= hcnt_ff + tlbpt_pkg::CNT_W'(1);
                  if (policy_ff) tcur_ff <= lk_idx;
               end else if (pmv_q) begin
                  if (policy_ff) fcur_ff <= pm_q;
               end else begin
                  if (fcnt_ff != '1) fcnt_ff <= fcnt_ff + tlbpt_pkg::CNT_W'(1);
               end
            end
            S_FNEXT: begin
               if (frsp.done) begin
                  fcur_ff <= fring_f;
                  pm_vld_ff[page_ff] <= 1'b1;
               end
            end
            S_OWN: begin
               own_vld_ff[frame_ff] <= 1'b1;
               if (ownv_q) begin
                  pm_vld_ff[own_q] <= 1'b0;
                  if (inv_hit) tvld_ff[inv_idx] <= 1'b0;
               end
            end
            S_TPREV: if (trsp.done) tcur_ff <= tring_t;
            S_TFILL: begin
               if (trsp.done) begin
                  tcur_ff <= tring_t;
                  tvld_ff[tring_t] <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // payload, TLB contents and map memories
   always_ff @(posedge clock) begin
      pm_q  <= pm_mem[req_logical_address[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFF_W]];
      pmv_q <= pm_vld_ff[req_logical_address[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFF_W]];
      own_q  <= own_mem[fring_f];
      ownv_q <= own_vld_ff[fring_f];
      case (state_ff)
         S_IDLE: begin
            page_ff  <= req_logical_address[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFF_W];
            off_ff   <= req_logical_address[tlbpt_pkg::OFF_W-1:0];
            hit_ff   <= 1'b0;
            fault_ff <= 1'b0;
            evv_ff   <= 1'b0;
            evp_ff   <= '0;
         end
         S_LOOK: begin
            if (lk_hit) begin
               hit_ff   <= 1'b1;
               frame_ff <= tdata_ff[lk_idx];
            end else if (pmv_q) begin
               frame_ff <= pm_q;
            end else begin
               fault_ff <= 1'b1;
            end
         end
         S_FNEXT: begin
            if (frsp.done) begin
               frame_ff <= fring_f;
               pm_mem[page_ff] <= fring_f;
            end
         end
         S_OWN: begin
            own_mem[frame_ff] <= page_ff;
            if (ownv_q) begin
               evv_ff <= 1'b1;
               evp_ff <= own_q;
            end
         end
         S_TFILL: begin
            if (trsp.done) begin
               ttag_ff[tring_t]  <= page_ff;
               tdata_ff[tring_t] <= frame_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid            = (state_ff == S_DONE);
   assign rsp_phys_addr        = {frame_ff, off_ff};
   assign rsp_frame_index      = frame_ff;
   assign rsp_tlb_hit          = hit_ff;
   assign rsp_page_fault       = fault_ff;
   assign rsp_evicted_valid    = evv_ff;
   assign rsp_evicted_page     = evp_ff;
   assign rsp_fault_total      = fcnt_ff;
   assign rsp_hit_total        = hcnt_ff;

endmodule
`default_nettype wire

// ===== rtl/core/tlbpt_checker.sv =====
// Port-level checker for the translator, bound to the top level.
`default_nettype none
module tlbpt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [15:0] rsp_phys_addr,
   input wire logic [7:0]  rsp_frame_index,
   input wire logic        rsp_tlb_hit,
   input wire logic        rsp_page_fault,
   input wire logic        rsp_evicted_valid,
   input wire logic [7:0]  rsp_evicted_page
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transaction accepted without busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tlb_hit |-> !rsp_page_fault && !rsp_evicted_valid)
      else $error("TLB hit reported with fault");

   a_evict_needs_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_valid |-> rsp_page_fault)
      else $error("eviction without fault");

   a_frame_in_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_phys_addr[15:8] == rsp_frame_index
                    && (rsp_evicted_valid || rsp_evicted_page == 8'd0))
      else $error("physical address or evicted page inconsistent");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_phys_addr        (rsp_phys_addr),
   .rsp_frame_index      (rsp_frame_index),
   .rsp_tlb_hit          (rsp_tlb_hit),
   .rsp_page_fault       (rsp_page_fault),
   .rsp_evicted_valid    (rsp_evicted_valid),
   .rsp_evicted_page     (rsp_evicted_page)
);
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for tlb_page_table_translator: directed table plus random traffic against a predictor.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TLB_N = 16;
   localparam int LIMIT_CYCLES = 600000;
   localparam int SETTLE = 40;
   localparam int CW = tlbpt_pkg::CNT_W;
   localparam logic [tlbpt_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = 8'd2;
   localparam logic [tlbpt_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 8'hFF;

   typedef struct packed {
      logic [tlbpt_pkg::ADDR_W-1:0]  phys;
      logic [tlbpt_pkg::FRAME_W-1:0] frame;
      logic                          tlb_hit;
      logic                          fault;
      logic                          ev_valid;
      logic [tlbpt_pkg::PAGE_W-1:0]  ev_page;
      logic [tlbpt_pkg::CNT_W-1:0]   fault_total;
      logic [tlbpt_pkg::CNT_W-1:0]   hit_total;
   } xlat_type;

   typedef struct {
      logic [tlbpt_pkg::ADDR_W-1:0] addr;
      bit                           typed;
      xlat_type                     want;
   } vector_type;

   logic clock, reset, start, busy;
   logic [tlbpt_pkg::ADDR_W-1:0] req_logical_address;
   logic rsp_valid;
   logic [tlbpt_pkg::ADDR_W-1:0] rsp_phys_addr;
   logic [tlbpt_pkg::FRAME_W-1:0] rsp_frame_index;
   logic rsp_tlb_hit, rsp_page_fault, rsp_evicted_valid;
   logic [tlbpt_pkg::PAGE_W-1:0] rsp_evicted_page;
   logic [tlbpt_pkg::CNT_W-1:0] rsp_fault_total, rsp_hit_total;
   logic csr_valid, csr_ready;
   logic [tlbpt_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tlbpt_pkg::CSR_DATA_W-1:0] csr_data;

   tlb_page_table_translator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_logical_address(req_logical_address),
      .rsp_valid(rsp_valid), .rsp_phys_addr(rsp_phys_addr),
      .rsp_frame_index(rsp_frame_index), .rsp_tlb_hit(rsp_tlb_hit),
      .rsp_page_fault(rsp_page_fault), .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_page(rsp_evicted_page), .rsp_fault_total(rsp_fault_total),
      .rsp_hit_total(rsp_hit_total), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   bit lru;
   int frames_n;
   bit pm_valid [tlbpt_pkg::PAGE_COUNT];
   int pm_frame [tlbpt_pkg::PAGE_COUNT];
   bit tlb_valid [TLB_N];
   int tlb_page [TLB_N];
   int tlb_frame [TLB_N];
   int tlb_nx [TLB_N];
   int tlb_pv [TLB_N];
   int tlb_cur;
   bit own_valid [tlbpt_pkg::MAX_FRAMES];
   int own_page [tlbpt_pkg::MAX_FRAMES];
   int frm_nx [tlbpt_pkg::MAX_FRAMES];
   int frm_pv [tlbpt_pkg::MAX_FRAMES];
   int frm_cur;
   logic [tlbpt_pkg::CNT_W-1:0] faults, hits;

   xlat_type pending_xlat [$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 0;

   function automatic void tlb_move(int head, int node);
      tlb_nx[tlb_pv[node]] = tlb_nx[node];
      tlb_pv[tlb_nx[node]] = tlb_pv[node];
      tlb_nx[node] = tlb_nx[head];
      tlb_pv[node] = head;
      tlb_pv[tlb_nx[head]] = node;
      tlb_nx[head] = node;
   endfunction

   function automatic void frame_move(int head, int node);
      frm_nx[frm_pv[node]] = frm_nx[node];
      frm_pv[frm_nx[node]] = frm_pv[node];
      frm_nx[node] = frm_nx[head];
      frm_pv[node] = head;
      frm_pv[frm_nx[head]] = node;
      frm_nx[head] = node;
   endfunction

   function automatic void clear_maps();
      for (int i = 0; i < tlbpt_pkg::PAGE_COUNT; i++) begin
         pm_valid[i] = 0;
         pm_frame[i] = 0;
      end
      for (int i = 0; i < TLB_N; i++) begin
         tlb_valid[i] = 0;
         tlb_page[i] = 0;
         tlb_frame[i] = 0;
         tlb_nx[i] = (i + 1) % TLB_N;
         tlb_pv[i] = (i + TLB_N - 1) % TLB_N;
      end
      tlb_cur = 0;
      for (int i = 0; i < tlbpt_pkg::MAX_FRAMES; i++) begin
         own_valid[i] = 0;
         own_page[i] = 0;
         frm_nx[i] = (i < frames_n) ? (i + 1) % frames_n : 0;
         frm_pv[i] = (i < frames_n) ? (i + frames_n - 1) % frames_n : 0;
      end
      frm_cur = frames_n - 1;
   endfunction

   function automatic void apply_csr(logic [tlbpt_pkg::CSR_IDX_W-1:0] idx,
                                     logic [tlbpt_pkg::CSR_DATA_W-1:0] data);
      int v;
      v = int'(data);
      if (idx == tlbpt_pkg::CSR_POLICY) begin
         lru = data[0];
      end else if (idx == tlbpt_pkg::CSR_FRAMES) begin
         if (v < 1) v = 1;
         if (v > tlbpt_pkg::MAX_FRAMES) v = tlbpt_pkg::MAX_FRAMES;
         frames_n = v;
         clear_maps();
      end
   endfunction

   function automatic logic [tlbpt_pkg::CNT_W-1:0] sat_inc(logic [tlbpt_pkg::CNT_W-1:0] v);
      return (v == '1) ? v : v + CW'(1);
   endfunction

   function automatic xlat_type translate(logic [tlbpt_pkg::ADDR_W-1:0] addr);
      xlat_type r;
      int pg, fr, hit_i, op;
      bit done;
      r = '0;
      pg = int'(addr[15:8]);
      hit_i = -1;
      for (int i = 0; i < TLB_N; i++)
         if (hit_i < 0 && tlb_valid[i] && tlb_page[i] == pg) hit_i = i;
      if (hit_i >= 0) begin
         r.tlb_hit = 1'b1;
         hits = sat_inc(hits);
         fr = tlb_frame[hit_i];
         if (lru && hit_i != tlb_cur) begin
            tlb_move(tlb_cur, hit_i);
            tlb_cur = hit_i;
         end
      end else begin
         if (!pm_valid[pg]) begin
            r.fault = 1'b1;
            faults = sat_inc(faults);
            fr = frm_nx[frm_cur];
            frm_cur = fr;
            pm_valid[pg] = 1;
            pm_frame[pg] = fr;
            if (own_valid[fr]) begin
               op = own_page[fr];
               r.ev_valid = 1'b1;
               r.ev_page = 8'(op);
               pm_valid[op] = 0;
               done = 0;
               for (int i = 0; i < TLB_N; i++) begin
                  if (!done && tlb_valid[i] && tlb_page[i] == op) begin
                     done = 1;
                     tlb_valid[i] = 0;
                     if (i != tlb_cur) tlb_move(tlb_cur, i);
                     else tlb_cur = tlb_pv[i];
                  end
               end
            end
            own_valid[fr] = 1;
            own_page[fr] = pg;
         end else begin
            fr = pm_frame[pg];
            if (lru && fr != frm_cur) begin
               frame_move(frm_cur, fr);
               frm_cur = fr;
            end
         end
         tlb_cur = tlb_nx[tlb_cur];
         tlb_valid[tlb_cur] = 1;
         tlb_page[tlb_cur] = pg;
         tlb_frame[tlb_cur] = fr;
      end
      r.frame = 8'(fr);
      r.phys = {r.frame, addr[7:0]};
      r.fault_total = faults;
      r.hit_total = hits;
      return r;
   endfunction

   function automatic void check_field(string name, logic [tlbpt_pkg::CNT_W-1:0] want,
                                       logic [tlbpt_pkg::CNT_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      end
   endfunction

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tlb_page_table_translator verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      xlat_type w;
      if (!reset && rsp_valid) begin
         if (pending_xlat.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none, actual phys %0h",
                     $realtime, rsp_phys_addr);
         end else begin
            w = pending_xlat.pop_front();
            check_field("phys_addr", CW'(w.phys), CW'(rsp_phys_addr));
            check_field("frame_index", CW'(w.frame), CW'(rsp_frame_index));
            check_field("tlb_hit", CW'(w.tlb_hit), CW'(rsp_tlb_hit));
            check_field("page_fault", CW'(w.fault), CW'(rsp_page_fault));
            check_field("evicted_valid", CW'(w.ev_valid), CW'(rsp_evicted_valid));
            check_field("evicted_page", CW'(w.ev_page), CW'(rsp_evicted_page));
            check_field("fault_total", w.fault_total, rsp_fault_total);
            check_field("hit_total", w.hit_total, rsp_hit_total);
         end
      end
   end

   task automatic idle_gap();
      if (!quiet) begin
         while ($urandom_range(99) < 22) begin
            start <= 0;
            @(posedge clock);
         end
      end
   endtask

   task automatic send(logic [tlbpt_pkg::ADDR_W-1:0] addr, bit typed, xlat_type want);
      xlat_type p;
      idle_gap();
      start <= 1;
      req_logical_address <= addr;
      do @(posedge clock); while (busy);
      p = translate(addr);
      pending_xlat.push_back(typed ? want : p);
   endtask

   task automatic drain();
      while (pending_xlat.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [tlbpt_pkg::CSR_IDX_W-1:0] idx,
                            logic [tlbpt_pkg::CSR_DATA_W-1:0] data);
      start <= 0;
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic random_run(int count, int pool);
      int base;
      logic [tlbpt_pkg::ADDR_W-1:0] a;
      base = int'($urandom_range(255));
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0) a = 16'($urandom_range(16'hFFFF));
         else a = {8'((base + $urandom_range(pool - 1)) % 256), 8'($urandom_range(255))};
         send(a, 0, '0);
         if (n == count / 2 && $urandom_range(1)) begin
            start <= 0;
            while (pending_xlat.size() != 0) @(posedge clock);
         end
      end
   endtask

   vector_type table_rows [] = '{
      '{16'h0000, 1'b1, '{16'h0000, 8'd0, 1'b0, 1'b1, 1'b0, 8'd0, 32'd1, 32'd0}},
      '{16'h00FF, 1'b1, '{16'h00FF, 8'd0, 1'b1, 1'b0, 1'b0, 8'd0, 32'd1, 32'd1}},
      '{16'hFFFF, 1'b1, '{16'h01FF, 8'd1, 1'b0, 1'b1, 1'b0, 8'd0, 32'd2, 32'd1}},
      '{16'hFF00, 1'b1, '{16'h0100, 8'd1, 1'b1, 1'b0, 1'b0, 8'd0, 32'd2, 32'd2}},
      '{16'h8080, 1'b0, '0}, '{16'h7F7F, 1'b0, '0}, '{16'h5555, 1'b0, '0},
      '{16'hAAAA, 1'b0, '0}, '{16'h0101, 1'b0, '0}, '{16'h0202, 1'b0, '0},
      '{16'h0303, 1'b0, '0}, '{16'h0404, 1'b0, '0}, '{16'h0505, 1'b0, '0},
      '{16'h0606, 1'b0, '0}, '{16'h0707, 1'b0, '0}, '{16'h0808, 1'b0, '0},
      '{16'h0909, 1'b0, '0}, '{16'h0A0A, 1'b0, '0}, '{16'h0B0B, 1'b0, '0},
      '{16'h0C0C, 1'b0, '0}, '{16'h0D0D, 1'b0, '0}, '{16'h0033, 1'b0, '0},
      '{16'hFF44, 1'b0, '0}, '{16'h0E0E, 1'b0, '0}
   };

   initial begin
      start <= 0;
      req_logical_address <= '0;
      csr_valid <= 0;
      csr_index <= '0;
      csr_data <= '0;
      reset <= 1;
      lru = 0;
      frames_n = tlbpt_pkg::MAX_FRAMES;
      faults = 0;
      hits = 0;
      clear_maps();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (table_rows[k]) send(table_rows[k].addr, table_rows[k].typed, table_rows[k].want);

      // one frame: every new page evicts the previous one
      write_csr(tlbpt_pkg::CSR_FRAMES, 9'd0);
      send(16'h1234, 0, '0);
      send(16'h5678, 0, '0);
      send(16'h1200, 0, '0);
      write_csr(CSR_UNUSED_LO, 9'h1FF);
      write_csr(CSR_UNUSED_HI, 9'h000);
      write_csr(tlbpt_pkg::CSR_POLICY, 9'h1FF);
      write_csr(tlbpt_pkg::CSR_FRAMES, 9'h1FF);
      send(16'hFFFF, 0, '0);

      quiet = 1;
      random_run(170, 40);
      quiet = 0;
      random_run(170, 300);
      write_csr(tlbpt_pkg::CSR_FRAMES, 9'd2);
      random_run(160, 5);
      write_csr(tlbpt_pkg::CSR_POLICY, 9'd0);
      random_run(160, 6);
      write_csr(tlbpt_pkg::CSR_FRAMES, 9'd256);
      random_run(180, 30);
      write_csr(tlbpt_pkg::CSR_FRAMES, 9'd17);
      random_run(160, 24);
      write_csr(tlbpt_pkg::CSR_POLICY, 9'd1);
      random_run(160, 24);
      write_csr(tlbpt_pkg::CSR_FRAMES, 9'd1);
      random_run(100, 3);
      write_csr(tlbpt_pkg::CSR_FRAMES, 9'd255);
      random_run(130, 256);

      start <= 0;
      drain();
      if (errors == 0 && pending_xlat.size() == 0) begin
         $display("tlb_page_table_translator verification clean");
      end else begin
         $display("tlb_page_table_translator verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
